@@ rtl/xpbd_distance_constraint_core_assert.svh @@
// assertion macros shared by the checker
`ifndef XPBD_DISTANCE_CONSTRAINT_CORE_ASSERT_SVH
`define XPBD_DISTANCE_CONSTRAINT_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define XDC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define XDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/xdc_pkg.sv @@
`default_nettype none

package xdc_pkg;

  // unit sizes
  localparam int SqrtSteps = 34;
  localparam int RadW      = 2 * SqrtSteps;
  localparam int RootW     = SqrtSteps;
  localparam int AdivSteps = 49;
  localparam int AlphaW    = AdivSteps;
  localparam int TsqW      = 34;
  localparam int CompW     = 17;
  localparam int DivSteps  = 31;
  localparam int DenW      = 50;
  localparam int NumW      = 33;
  localparam int MulAW     = 34;
  localparam int MulBW     = 31;
  localparam int MulLat    = 2;

  // pipeline stage numbers (register set after that many edges)
  localparam int StIn    = 1;
  localparam int StSq    = 2;
  localparam int StSum   = 3;
  localparam int StLen   = StSum + SqrtSteps;
  localparam int StAlpha = StSq + AdivSteps;
  localparam int StDen   = StAlpha + 1;
  localparam int StDiv   = StDen + DivSteps;
  localparam int StS     = StDiv + MulLat;
  localparam int StMove  = StS + MulLat;
  localparam int Lat     = StMove + 1;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_REST_LENGTH = 2'd0,
    REG_COMPLIANCE  = 2'd1,
    REG_TIME_STEP   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic [23:0]        first_inv_mass;
    logic [23:0]        second_inv_mass;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] new_first_x;
    logic signed [31:0] new_first_y;
    logic signed [31:0] new_first_z;
    logic signed [31:0] new_second_x;
    logic signed [31:0] new_second_y;
    logic signed [31:0] new_second_z;
    logic               degenerate;
  } out_item_t;

endpackage

`default_nettype wire

@@ rtl/xdc_sqrt.sv @@
`default_nettype none

// pipelined integer square root, one root bit per stage
module xdc_sqrt import xdc_pkg::*; (
  input  wire logic             clk,
  input  wire logic [RadW-1:0]  rad_i,
  output logic      [RootW-1:0] root_o
);

  localparam int RemW = RootW + 2;
  localparam int AccW = RootW + 4;

  logic [RadW-1:0]  rad_r  [SqrtSteps];
  logic [RemW-1:0]  rem_r  [SqrtSteps];
  logic [RootW-1:0] root_r [SqrtSteps];

  for (genvar j = 0; j < SqrtSteps; j++) begin : g_step
    logic [RadW-1:0]  rad_in;
    logic [RemW-1:0]  rem_in;
    logic [RootW-1:0] root_in;
    logic [AccW-1:0]  acc;
    logic [AccW-1:0]  trial;

    if (j == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_r[j-1];
      assign rem_in  = rem_r[j-1];
      assign root_in = root_r[j-1];
    end

    // bring down the next bit pair and try the new root bit
    assign acc   = {rem_in, rad_in[RadW-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk) begin
      rad_r[j] <= rad_in << 2;
      if (acc >= trial) begin
        rem_r[j]  <= RemW'(acc - trial);
        root_r[j] <= {root_in[RootW-2:0], 1'b1};
      end else begin
        rem_r[j]  <= acc[RemW-1:0];
        root_r[j] <= {root_in[RootW-2:0], 1'b0};
      end
    end
  end

  assign root_o = root_r[SqrtSteps-1];

endmodule

`default_nettype wire

@@ rtl/xdc_adiv.sv @@
`default_nettype none

// pipelined divider for compliance * 2^32 / time_step^2
module xdc_adiv import xdc_pkg::*; (
  input  wire logic              clk,
  input  wire logic [CompW-1:0]  comp_i,
  input  wire logic [TsqW-1:0]   tsq_i,
  output logic      [AlphaW-1:0] alpha_o
);

  logic [TsqW-1:0]   rem_r  [AdivSteps];
  logic [AlphaW-1:0] q_r    [AdivSteps];
  logic [CompW-1:0]  comp_r [AdivSteps];
  logic [TsqW-1:0]   d_r    [AdivSteps];

  for (genvar j = 0; j < AdivSteps; j++) begin : g_step
    localparam int Bit = AdivSteps - 1 - j;
    logic [TsqW-1:0]   rem_in;
    logic [AlphaW-1:0] q_in;
    logic [CompW-1:0]  comp_in;
    logic [TsqW-1:0]   d_in;
    logic              nbit;
    logic [TsqW:0]     x;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign q_in    = '0;
      assign comp_in = comp_i;
      assign d_in    = tsq_i;
    end else begin : g_next
      assign rem_in  = rem_r[j-1];
      assign q_in    = q_r[j-1];
      assign comp_in = comp_r[j-1];
      assign d_in    = d_r[j-1];
    end

    // dividend bit: compliance sits above 32 zero bits
    if (Bit >= 32) begin : g_cbit
      assign nbit = comp_in[Bit-32];
    end else begin : g_zbit
      assign nbit = 1'b0;
    end

    assign x = {rem_in, nbit};

    always_ff @(posedge clk) begin
      comp_r[j] <= comp_in;
      d_r[j]    <= d_in;
      if (x >= {1'b0, d_in}) begin
        rem_r[j] <= TsqW'(x - {1'b0, d_in});
        q_r[j]   <= {q_in[AlphaW-2:0], 1'b1};
      end else begin
        rem_r[j] <= x[TsqW-1:0];
        q_r[j]   <= {q_in[AlphaW-2:0], 1'b0};
      end
    end
  end

  assign alpha_o = q_r[AdivSteps-1];

endmodule

`default_nettype wire

@@ rtl/xdc_div.sv @@
`default_nettype none

// pipelined divider for num * 2^30 / den, valid where num <= den
module xdc_div import xdc_pkg::*; (
  input  wire logic                clk,
  input  wire logic [NumW-1:0]     num_i,
  input  wire logic [DenW-1:0]     den_i,
  output logic      [DivSteps-1:0] quot_o
);

  logic [DenW-1:0]     rem_r [DivSteps];
  logic [DivSteps-1:0] q_r   [DivSteps];
  logic [DenW-1:0]     d_r   [DivSteps];

  for (genvar j = 0; j < DivSteps; j++) begin : g_step
    logic [DenW-1:0]     rem_in;
    logic [DivSteps-1:0] q_in;
    logic [DenW-1:0]     d_in;
    logic                nbit;
    logic [DenW:0]       x;

    // the numerator's lowest bit enters on the first step, zeros after
    if (j == 0) begin : g_first
      assign rem_in = DenW'(num_i >> 1);
      assign q_in   = '0;
      assign d_in   = den_i;
      assign nbit   = num_i[0];
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign q_in   = q_r[j-1];
      assign d_in   = d_r[j-1];
      assign nbit   = 1'b0;
    end

    assign x = {rem_in, nbit};

    always_ff @(posedge clk) begin
      d_r[j] <= d_in;
      if (x >= {1'b0, d_in}) begin
        rem_r[j] <= DenW'(x - {1'b0, d_in});
        q_r[j]   <= {q_in[DivSteps-2:0], 1'b1};
      end else begin
        rem_r[j] <= x[DenW-1:0];
        q_r[j]   <= {q_in[DivSteps-2:0], 1'b0};
      end
    end
  end

  assign quot_o = q_r[DivSteps-1];

endmodule

`default_nettype wire

@@ rtl/xdc_mul.sv @@
`default_nettype none

// two-stage a * b / 2^30, a split in two halves
module xdc_mul import xdc_pkg::*; (
  input  wire logic             clk,
  input  wire logic [MulAW-1:0] a_i,
  input  wire logic [MulBW-1:0] b_i,
  output logic      [MulAW-1:0] p_o
);

  localparam int HalfW = MulAW / 2;
  localparam int PartW = HalfW + MulBW;
  localparam int FullW = PartW + HalfW;

  logic [PartW-1:0] lo_r;
  logic [PartW-1:0] hi_r;
  logic [FullW-1:0] full;
  logic [MulAW-1:0] p_r;

  // partial products
  always_ff @(posedge clk) begin
    lo_r <= PartW'(a_i[HalfW-1:0]) * PartW'(b_i);
    hi_r <= PartW'(a_i[MulAW-1:HalfW]) * PartW'(b_i);
  end

  // recombine and drop 30 fraction bits
  assign full = {hi_r, {HalfW{1'b0}}} + FullW'(lo_r);

  always_ff @(posedge clk) begin
    p_r <= full[30 +: MulAW];
  end

  assign p_o = p_r;

endmodule

`default_nettype wire

@@ rtl/xpbd_distance_constraint_core.sv @@
`default_nettype none

// channel   ports                               item taken when
// input     start, busy, in_data                start && !busy
// result    out_strobe, out_item                out_strobe, one cycle only
// config    cfg_valid, cfg_ready, cfg_index,    cfg_valid && cfg_ready
//           cfg_data
//
// one item accepted per cycle while busy is low; results leave in the order accepted
// the pipeline runs through the 49-step alpha divider, the 31-step share and
// gradient dividers and two 2-stage multipliers in series
// synchronous active-low reset clears valid bits and sets configuration to defaults;
// busy is high during reset and in the cycle after it, low otherwise
// the pipeline never holds: results cannot be stalled by the receiver
module xpbd_distance_constraint_core import xdc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  in_data,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output logic           out_strobe,
  output out_item_t      out_item
);

  typedef struct packed {
    logic [2:0][31:0]   p1;
    logic [2:0][31:0]   p2;
    logic [2:0][NumW-1:0] mag;
    logic [2:0]         neg;
    logic [23:0]        w1;
    logic [23:0]        w2;
  } side_t;

  typedef struct packed {
    logic             cneg;
    logic             degen;
    logic [MulAW-1:0] cm;
  } sol_t;

  function automatic logic [31:0] sat32(input logic [35:0] v);
    logic [31:0] res;
    if (v[35:31] == 5'b00000 || v[35:31] == 5'b11111) begin
      res = v[31:0];
    end else if (v[35]) begin
      res = 32'h8000_0000;
    end else begin
      res = 32'h7FFF_FFFF;
    end
    return res;
  endfunction

  logic [30:0]      rest_r;
  logic [CompW-1:0] comp_r;
  logic [16:0]      tstep_r;
  logic             busy_r;
  logic             accept;

  logic             vld_r  [1:Lat];
  side_t            side_r [1:StMove];
  side_t            side_nxt;

  logic [65:0]      sq_r [3];
  logic [16:0]      tstep_eff;
  logic [TsqW-1:0]  tsq_r;
  logic [RadW-1:0]  sum_r;
  logic [RootW-1:0] root;
  logic [RootW-1:0] len_r [StLen+1:StAlpha];
  logic [AlphaW-1:0] alpha;

  logic [DenW-1:0]  den_nxt;
  logic [DenW-1:0]  den_r;
  logic [DenW-1:0]  glen_r;
  logic signed [RootW:0] c_nxt;
  sol_t             sol_nxt;
  sol_t             sol_r [StDen:StMove];

  logic [DivSteps-1:0] k1;
  logic [DivSteps-1:0] k2;
  logic [DivSteps-1:0] g   [3];
  logic [DivSteps-1:0] g1_r [3];
  logic [DivSteps-1:0] g2_r [3];
  logic [MulAW-1:0]    s1;
  logic [MulAW-1:0]    s2;
  logic [MulAW-1:0]    m1 [3];
  logic [MulAW-1:0]    m2 [3];

  logic [2:0][31:0] r1;
  logic [2:0][31:0] r2;
  out_item_t        out_nxt;
  out_item_t        out_r;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_r  <= 31'd65536;
      comp_r  <= '0;
      tstep_r <= 17'd1092;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_REST_LENGTH: rest_r  <= cfg_data[30:0];
        REG_COMPLIANCE:  comp_r  <= cfg_data[CompW-1:0];
        REG_TIME_STEP:   tstep_r <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // input handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 1; n <= Lat; n++) begin
        vld_r[n] <= 1'b0;
      end
    end else begin
      vld_r[1] <= accept;
      for (int n = 2; n <= Lat; n++) begin
        vld_r[n] <= vld_r[n-1];
      end
    end
  end

  // separation vector and its magnitudes
  always_comb begin
    logic signed [32:0] dd;
    side_nxt.p1[0] = in_data.first_x;
    side_nxt.p1[1] = in_data.first_y;
    side_nxt.p1[2] = in_data.first_z;
    side_nxt.p2[0] = in_data.second_x;
    side_nxt.p2[1] = in_data.second_y;
    side_nxt.p2[2] = in_data.second_z;
    side_nxt.w1    = in_data.first_inv_mass;
    side_nxt.w2    = in_data.second_inv_mass;
    for (int i = 0; i < 3; i++) begin
      dd = $signed({side_nxt.p2[i][31], side_nxt.p2[i]})
         - $signed({side_nxt.p1[i][31], side_nxt.p1[i]});
      side_nxt.neg[i] = dd[32];
      side_nxt.mag[i] = dd[32] ? NumW'(-dd) : NumW'(dd);
    end
  end

  // side data carried along the pipeline
  always_ff @(posedge clk) begin
    side_r[1] <= side_nxt;
    for (int n = 2; n <= StMove; n++) begin
      side_r[n] <= side_r[n-1];
    end
  end

  // squares and time step squared
  assign tstep_eff = (tstep_r == '0) ? 17'd1 : tstep_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq_r[i] <= 66'(side_r[StIn].mag[i]) * 66'(side_r[StIn].mag[i]);
    end
    tsq_r <= TsqW'(tstep_eff) * TsqW'(tstep_eff);
  end

  // squared length
  always_ff @(posedge clk) begin
    sum_r <= RadW'(sq_r[0]) + RadW'(sq_r[1]) + RadW'(sq_r[2]);
  end

  xdc_sqrt u_sqrt (
    .clk    (clk),
    .rad_i  (sum_r),
    .root_o (root)
  );

  xdc_adiv u_adiv (
    .clk     (clk),
    .comp_i  (comp_r),
    .tsq_i   (tsq_r),
    .alpha_o (alpha)
  );

  // hold the length until alpha is ready
  always_ff @(posedge clk) begin
    len_r[StLen+1] <= root;
    for (int n = StLen + 2; n <= StAlpha; n++) begin
      len_r[n] <= len_r[n-1];
    end
  end

  // denominator, violation and degenerate check
  always_comb begin
    den_nxt = DenW'(side_r[StAlpha].w1) + DenW'(side_r[StAlpha].w2) + DenW'(alpha);
    c_nxt   = $signed({1'b0, len_r[StAlpha]})
            - $signed({{(RootW - 30){1'b0}}, rest_r});
    sol_nxt.cneg  = c_nxt[RootW];
    sol_nxt.cm    = c_nxt[RootW] ? MulAW'(-c_nxt) : MulAW'(c_nxt);
    sol_nxt.degen = (len_r[StAlpha] == '0) || (den_nxt == '0);
  end

  always_ff @(posedge clk) begin
    den_r         <= den_nxt;
    glen_r        <= DenW'(len_r[StAlpha]);
    sol_r[StDen]  <= sol_nxt;
    for (int n = StDen + 1; n <= StMove; n++) begin
      sol_r[n] <= sol_r[n-1];
    end
  end

  // inverse mass shares
  xdc_div u_div_k1 (
    .clk    (clk),
    .num_i  (NumW'(side_r[StDen].w1)),
    .den_i  (den_r),
    .quot_o (k1)
  );

  xdc_div u_div_k2 (
    .clk    (clk),
    .num_i  (NumW'(side_r[StDen].w2)),
    .den_i  (den_r),
    .quot_o (k2)
  );

  // unit gradient per axis
  for (genvar i = 0; i < 3; i++) begin : g_axis
    xdc_div u_div_g (
      .clk    (clk),
      .num_i  (side_r[StDen].mag[i]),
      .den_i  (glen_r),
      .quot_o (g[i])
    );

    always_ff @(posedge clk) begin
      g1_r[i] <= g[i];
      g2_r[i] <= g1_r[i];
    end

    xdc_mul u_mul_m1 (
      .clk (clk),
      .a_i (s1),
      .b_i (g2_r[i]),
      .p_o (m1[i])
    );

    xdc_mul u_mul_m2 (
      .clk (clk),
      .a_i (s2),
      .b_i (g2_r[i]),
      .p_o (m2[i])
    );
  end

  // step lengths
  xdc_mul u_mul_s1 (
    .clk (clk),
    .a_i (sol_r[StDiv].cm),
    .b_i (k1),
    .p_o (s1)
  );

  xdc_mul u_mul_s2 (
    .clk (clk),
    .a_i (sol_r[StDiv].cm),
    .b_i (k2),
    .p_o (s2)
  );

  // apply moves with sign and saturate, or pass positions through when degenerate
  always_comb begin
    logic        pos;
    logic [35:0] a1;
    logic [35:0] a2;
    logic [35:0] b1;
    logic [35:0] b2;
    for (int i = 0; i < 3; i++) begin
      pos = (side_r[StMove].neg[i] == sol_r[StMove].cneg);
      a1  = {{4{side_r[StMove].p1[i][31]}}, side_r[StMove].p1[i]};
      a2  = {{4{side_r[StMove].p2[i][31]}}, side_r[StMove].p2[i]};
      b1  = {2'b00, m1[i]};
      b2  = {2'b00, m2[i]};
      if (sol_r[StMove].degen) begin
        r1[i] = side_r[StMove].p1[i];
        r2[i] = side_r[StMove].p2[i];
      end else begin
        r1[i] = sat32(pos ? a1 + b1 : a1 - b1);
        r2[i] = sat32(pos ? a2 - b2 : a2 + b2);
      end
    end
    out_nxt.new_first_x  = r1[0];
    out_nxt.new_first_y  = r1[1];
    out_nxt.new_first_z  = r1[2];
    out_nxt.new_second_x = r2[0];
    out_nxt.new_second_y = r2[1];
    out_nxt.new_second_z = r2[2];
    out_nxt.degenerate   = sol_r[StMove].degen;
  end

  // result register
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_item   = out_r;
  assign out_strobe = vld_r[Lat];

endmodule

`default_nettype wire

@@ rtl/xdc_checker.sv @@
`default_nettype none

`include "xpbd_distance_constraint_core_assert.svh"

// port-level checks on the constraint core
module xdc_checker import xdc_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire in_item_t  in_data,
  input wire logic      out_strobe,
  input wire out_item_t out_item
);

  // every result traces back to an accepted item
  `XDC_ASSERT_IMPL(a_result_from_item, clk, rst_n, out_strobe, $past(start && !busy, Lat), "result without item")

  // a skipped solve returns the positions untouched (checked on first_x and second_z)
  `XDC_ASSERT_IMPL(a_degen_pass, clk, rst_n, out_strobe && out_item.degenerate, (out_item.new_first_x == $past(in_data.first_x, Lat)) && (out_item.new_second_z == $past(in_data.second_z, Lat)), "degenerate item moved")

  // a fixed first particle never moves
  `XDC_ASSERT_IMPL(a_fixed_first, clk, rst_n, out_strobe && ($past(in_data.first_inv_mass, Lat) == '0), (out_item.new_first_x == $past(in_data.first_x, Lat)) && (out_item.new_first_y == $past(in_data.first_y, Lat)) && (out_item.new_first_z == $past(in_data.first_z, Lat)), "fixed particle moved")

  // items are never held off for long: busy is low in the cycle after any cycle in which it is high
  `XDC_ASSERT_NEXT(a_busy_short, clk, rst_n, busy, !busy, "busy held")

endmodule

bind xpbd_distance_constraint_core xdc_checker u_xdc_checker (.*);

`default_nettype wire
